[hdl/vir_pkg.sv]
// shared constants, types and helpers for the voxel interior removal unit
package vir_pkg;

	localparam int MAX_SIDE   = 32;
	localparam int VALUE_BITS = 16;
	localparam int COORD_W    = $clog2(MAX_SIDE);
	localparam int SIZE_W     = COORD_W + 1;
	localparam int ADDR_W     = 3 * COORD_W;
	localparam int DEPTH      = MAX_SIDE * MAX_SIDE * MAX_SIDE;
	localparam int PLANE_W    = 2 * COORD_W + 1;
	localparam int TOTAL_W    = ADDR_W + 1;
	localparam int PADDR_W    = 5;

	localparam logic [2:0] REG_SIZE_X       = 3'd0;
	localparam logic [2:0] REG_SIZE_Y       = 3'd1;
	localparam logic [2:0] REG_SIZE_Z       = 3'd2;
	localparam logic [2:0] REG_FULL_CONNECT = 3'd3;
	localparam logic [2:0] REG_OCC_LEVEL    = 3'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROW   = 6'b000010,
		S_CTR   = 6'b000100,
		S_SCAN  = 6'b001000,
		S_DRAIN = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] r;
		if (s == '0) begin
			r = SIZE_W'(1);
		end else if (s > SIZE_W'(MAX_SIDE)) begin
			r = SIZE_W'(MAX_SIDE);
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

[hdl/vir_ram.sv]
// generic single-port ram with registered read
module vir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

[hdl/voxel_interior_removal_unit.sv]
// voxel interior removal unit: top level with voxel store and neighbor scan
// load transaction: written to the store on acceptance, the next input may follow at once
// read transaction: row, center, scan, drain, done; no new input until back in idle;
//   the center and all 26 neighbors are fetched one per cycle from the single-port store
// a configuration write holds off input while the volume products settle
// reset clears positions, registers and handshake state; the voxel store is not cleared
module voxel_interior_removal_unit
	import vir_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VALUE_BITS-1:0]  s_tdata,  // voxel_value
	input  logic                   s_tuser,  // command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [VALUE_BITS-1:0]  m_tdata,  // filtered_value
	output logic                   m_tuser,  // was_interior
	output logic                   m_tlast   // last_voxel
);

	logic [SIZE_W-1:0]      size_x_q, size_y_q, size_z_q;
	logic                   full_q;
	logic signed [15:0]     level_q;
	logic [1:0]             settle_q;

	logic [SIZE_W-1:0]      csx, csy, csz;
	logic [PLANE_W-1:0]     plane_q;
	logic [TOTAL_W-1:0]     total_q;

	state_t                 state_q;
	logic [ADDR_W-1:0]      load_pos_q;
	logic [COORD_W-1:0]     x_q, y_q, z_q;
	logic [2*COORD_W:0]     row_q;
	logic [ADDR_W-1:0]      ctr_q;
	logic [1:0]             dx_q, dy_q, dz_q;
	logic                   issue_s1, center_s1, rel_s1;
	logic                   interior_q, last_q;
	logic [VALUE_BITS-1:0]  value_q;

	logic                   m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [VALUE_BITS-1:0]  m_tdata_q;

	logic                   cfg_wr, in_acc, out_free;
	logic [ADDR_W-1:0]      load_eff;
	logic [TOTAL_W-1:0]     load_next;
	logic                   coord_out;
	logic [ADDR_W-1:0]      off_x, off_y, off_z, nbr_addr;
	logic                   mem_we;
	logic [ADDR_W-1:0]      mem_addr;
	logic [VALUE_BITS-1:0]  mem_rdata;
	logic                   is_center, is_face, scan_end;
	logic [SIZE_W-1:0]      x_inc, y_inc, z_inc;
	logic                   eligible, last_now;
	logic [2*COORD_W:0]     row_prod;
	logic [2*COORD_W+SIZE_W:0] ctr_prod;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[4:2])
			REG_SIZE_X:       prdata = {{(32-SIZE_W){1'b0}}, size_x_q};
			REG_SIZE_Y:       prdata = {{(32-SIZE_W){1'b0}}, size_y_q};
			REG_SIZE_Z:       prdata = {{(32-SIZE_W){1'b0}}, size_z_q};
			REG_FULL_CONNECT: prdata = {31'd0, full_q};
			REG_OCC_LEVEL:    prdata = {16'd0, level_q};
			default:          prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_W'(MAX_SIDE);
			size_y_q <= SIZE_W'(MAX_SIDE);
			size_z_q <= SIZE_W'(MAX_SIDE);
			full_q   <= 1'b0;
			level_q  <= 16'sd26;
			settle_q <= 2'd2;
		end else begin
			if (cfg_wr) begin
				settle_q <= 2'd2;
				case (paddr[4:2])
					REG_SIZE_X:       size_x_q <= pwdata[SIZE_W-1:0];
					REG_SIZE_Y:       size_y_q <= pwdata[SIZE_W-1:0];
					REG_SIZE_Z:       size_z_q <= pwdata[SIZE_W-1:0];
					REG_FULL_CONNECT: full_q   <= pwdata[0];
					REG_OCC_LEVEL:    level_q  <= pwdata[15:0];
					default: ;
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	assign csx = clamp_size(size_x_q);
	assign csy = clamp_size(size_y_q);
	assign csz = clamp_size(size_z_q);

	always_ff @(posedge clk) begin
		plane_q <= PLANE_W'(csx * csy);
		total_q <= TOTAL_W'(plane_q * csz);
	end

	assign s_tready = (state_q == S_IDLE) && (settle_q == 2'd0);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign load_eff  = ({1'b0, load_pos_q} >= total_q) ? '0 : load_pos_q;
	assign load_next = {1'b0, load_eff} + TOTAL_W'(1);
	assign coord_out = ({1'b0, x_q} >= csx) || ({1'b0, y_q} >= csy) || ({1'b0, z_q} >= csz);

	assign off_x = (dx_q == 2'd0) ? '1 : (dx_q == 2'd2) ? ADDR_W'(1) : '0;
	assign off_y = (dy_q == 2'd0) ? -ADDR_W'(csx) : (dy_q == 2'd2) ? ADDR_W'(csx) : '0;
	assign off_z = (dz_q == 2'd0) ? -ADDR_W'(plane_q) :
		(dz_q == 2'd2) ? ADDR_W'(plane_q) : '0;
	assign nbr_addr = ctr_q + off_x + off_y + off_z;

	assign mem_we   = in_acc && (s_tuser == CMD_LOAD);
	assign mem_addr = (state_q == S_SCAN) ? nbr_addr : load_eff;

	vir_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (s_tdata),
		.rdata (mem_rdata)
	);

	assign is_center = (dx_q == 2'd1) && (dy_q == 2'd1) && (dz_q == 2'd1);
	assign is_face   = ((dx_q != 2'd1) + (dy_q != 2'd1) + (dz_q != 2'd1)) == 2'd1;
	assign scan_end  = (dx_q == 2'd2) && (dy_q == 2'd2) && (dz_q == 2'd2);

	assign x_inc = {1'b0, x_q} + SIZE_W'(1);
	assign y_inc = {1'b0, y_q} + SIZE_W'(1);
	assign z_inc = {1'b0, z_q} + SIZE_W'(1);

	assign eligible = (x_q != '0) && (x_inc < csx) && (y_q != '0) && (y_inc < csy) &&
		(z_q != '0) && (z_inc < csz);
	assign last_now = (x_inc == csx) && (y_inc == csy) && (z_inc == csz);

	assign row_prod = (2*COORD_W+1)'(z_q * csy) + (2*COORD_W+1)'(y_q);
	assign ctr_prod = row_q * csx + (2*COORD_W+SIZE_W+1)'(x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_pos_q <= '0;
			x_q        <= '0;
			y_q        <= '0;
			z_q        <= '0;
			dx_q       <= '0;
			dy_q       <= '0;
			dz_q       <= '0;
			issue_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			issue_s1 <= (state_q == S_SCAN);
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (s_tuser == CMD_LOAD) begin
							load_pos_q <= (load_next >= total_q) ? '0 : load_next[ADDR_W-1:0];
						end else begin
							if (coord_out) begin
								x_q <= '0;
								y_q <= '0;
								z_q <= '0;
							end
							state_q <= S_ROW;
						end
					end
				end
				S_ROW: begin
					state_q <= S_CTR;
				end
				S_CTR: begin
					dx_q    <= '0;
					dy_q    <= '0;
					dz_q    <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (dx_q == 2'd2) begin
						dx_q <= '0;
						if (dy_q == 2'd2) begin
							dy_q <= '0;
							dz_q <= (dz_q == 2'd2) ? 2'd0 : dz_q + 2'd1;
						end else begin
							dy_q <= dy_q + 2'd1;
						end
					end else begin
						dx_q <= dx_q + 2'd1;
					end
					if (scan_end) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						if (x_inc >= csx) begin
							x_q <= '0;
							if (y_inc >= csy) begin
								y_q <= '0;
								z_q <= (z_inc >= csz) ? '0 : z_inc[COORD_W-1:0];
							end else begin
								y_q <= y_inc[COORD_W-1:0];
							end
						end else begin
							x_q <= x_inc[COORD_W-1:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ROW) begin
			row_q <= row_prod;
		end
		if (state_q == S_CTR) begin
			ctr_q      <= ctr_prod[ADDR_W-1:0];
			interior_q <= eligible;
			last_q     <= last_now;
		end
		center_s1 <= is_center;
		rel_s1    <= !is_center && (full_q || is_face);
		if (issue_s1) begin
			if (center_s1) begin
				value_q <= mem_rdata;
			end
			if ((center_s1 || rel_s1) && ($signed(mem_rdata) < level_q)) begin
				interior_q <= 1'b0;
			end
		end
		if ((state_q == S_DONE) && out_free) begin
			m_tdata_q <= interior_q ? '0 : value_q;
			m_tuser_q <= interior_q;
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == S_IDLE))
		else $error("input ready outside idle");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_IDLE) && !issue_s1)
		else $error("store write during neighbor scan");
	a_interior_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("interior voxel not cleared");
	a_scan_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> (dx_q == 2'd0) && (dy_q == 2'd0) && (dz_q == 2'd0))
		else $error("neighbor counters did not wrap");
`endif

endmodule
